[hdl/servo_duty_ramp_unit_assert.svh]
// ============================================================================
// Servo duty ramp assertion macros
// Concurrent assertion wrappers used by the servo duty ramp checker.
// ============================================================================
`ifndef SERVO_DUTY_RAMP_UNIT_ASSERT_SVH
`define SERVO_DUTY_RAMP_UNIT_ASSERT_SVH

// check while out of reset
`define SDR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// check on every edge, reset included
`define SDR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[hdl/sdr_pkg.sv]
// ============================================================================
// Servo duty ramp package
// Widths, codes, word structs and constant tables of the servo duty ramp.
// ============================================================================
package sdr_pkg;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned SPEED_W   = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned DUTY_W    = 22;
    localparam int unsigned STEP_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 7;

    localparam logic [DUTY_W-1:0] DUTY_MIN     = 22'd600000;
    localparam logic [DUTY_W-1:0] DUTY_MAX     = 22'd3140000;
    localparam logic [DUTY_W-1:0] DUTY_PER_POS = 22'd20000;

    localparam logic [POS_W-1:0] MIN_POS_RST     = 7'd0;
    localparam logic [POS_W-1:0] MAX_POS_RST     = 7'd100;
    localparam logic [POS_W-1:0] STANDBY_POS_RST = 7'd50;

    // step = floor(|diff| * speed / 100) via per-speed reciprocal
    localparam int unsigned SPEED_SCALE = 100;
    localparam int unsigned RECIP_SH    = 29;
    localparam int unsigned RECIP_W     = 31;
    localparam int unsigned PROD_W      = DUTY_W + RECIP_W;
    localparam int unsigned QUOT_W      = STEP_W - 1;

    // position = floor((duty - min) / 32 / 625) via reciprocal
    localparam int unsigned POS_SHIFT   = 5;
    localparam int unsigned POS_NUM_W   = DUTY_W - POS_SHIFT;
    localparam int unsigned POS_RECIP_W = 17;
    localparam int unsigned POS_RECIP_SH = 26;
    localparam int unsigned POS_PROD_W  = POS_NUM_W + POS_RECIP_W;
    localparam logic [POS_RECIP_W-1:0] POS_RECIP = 17'd107375;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_MOVE      = 3'd1,
        OP_STANDBY   = 3'd2,
        OP_STOP      = 3'd3,
        OP_POWER_OFF = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_RANGE      = 2'd1,
        ST_SAME       = 2'd2,
        ST_ZERO_SPEED = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_POS     = 2'd0,
        CFG_MAX_POS     = 2'd1,
        CFG_STANDBY_POS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [POS_W-1:0]   target_position;
        logic [SPEED_W-1:0] ramp_speed;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [DUTY_W-1:0] duty_ns;
        logic              duty_written;
        logic              powered;
    } result_t;

    typedef logic [RECIP_W-1:0] recip_tab_t [2**SPEED_W];

    function automatic recip_tab_t build_recip_tab();
        recip_tab_t tab;
        for (int i = 0; i < 2**SPEED_W; i++) begin
            tab[i] = RECIP_W'(((64'(i) << RECIP_SH) + 64'(SPEED_SCALE - 1))
                              / 64'(SPEED_SCALE));
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip_tab();

    function automatic logic [DUTY_W-1:0] duty_for_pos(input logic [POS_W-1:0] pos);
        logic [DUTY_W-1:0] scaled;
        scaled = DUTY_W'(pos) * DUTY_PER_POS;
        return scaled + DUTY_MIN;
    endfunction

endpackage

[hdl/sdr_core.sv]
// ============================================================================
// Servo duty ramp core
// Configuration and ramp state, one-pass item update and the result register.
// ============================================================================
module sdr_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [sdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdr_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    input  sdr_pkg::item_t                    in_item,
    output logic                              in_take,
    output logic                              res_valid,
    output sdr_pkg::result_t                  res,
    input  logic                              res_take
);

    logic [sdr_pkg::POS_W-1:0]   min_pos_reg, max_pos_reg, stby_pos_reg;
    logic [sdr_pkg::DUTY_W-1:0]  cur_reg, cur_next;
    logic [sdr_pkg::DUTY_W-1:0]  tgt_reg, tgt_next;
    logic [sdr_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        ramp_reg, ramp_next;
    logic                        pwr_reg, pwr_next;
    logic                        res_valid_reg;
    sdr_pkg::result_t            res_reg, res_next;

    sdr_pkg::op_t                op;
    logic [sdr_pkg::DUTY_W-1:0]  want;
    logic [sdr_pkg::DUTY_W-1:0]  stby_duty;
    logic [sdr_pkg::DUTY_W:0]    diff;
    logic [sdr_pkg::DUTY_W-1:0]  mag;
    logic [sdr_pkg::RECIP_W-1:0] recip;
    logic [sdr_pkg::PROD_W-1:0]  prod;
    logic [sdr_pkg::QUOT_W-1:0]  quot;
    logic [sdr_pkg::STEP_W-1:0]  step_calc;
    logic [sdr_pkg::DUTY_W+3:0]  sum;
    logic [sdr_pkg::DUTY_W+3:0]  tgt_ext;
    logic                        step_pos;

    assign in_take   = in_valid && (!res_valid_reg || res_take);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pos_reg  <= sdr_pkg::MIN_POS_RST;
            max_pos_reg  <= sdr_pkg::MAX_POS_RST;
            stby_pos_reg <= sdr_pkg::STANDBY_POS_RST;
        end else if (cfg_we) begin
            unique case (sdr_pkg::cfg_idx_t'(cfg_index))
                sdr_pkg::CFG_MIN_POS:     min_pos_reg  <= cfg_wdata;
                sdr_pkg::CFG_MAX_POS:     max_pos_reg  <= cfg_wdata;
                sdr_pkg::CFG_STANDBY_POS: stby_pos_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        op        = sdr_pkg::op_t'(in_item.operation);
        want      = sdr_pkg::duty_for_pos(in_item.target_position);
        stby_duty = sdr_pkg::duty_for_pos(stby_pos_reg);

        diff  = {1'b0, want} - {1'b0, cur_reg};
        mag   = diff[sdr_pkg::DUTY_W] ? sdr_pkg::DUTY_W'(~diff + 1'b1)
                                      : diff[sdr_pkg::DUTY_W-1:0];
        recip = sdr_pkg::RECIP_TAB[in_item.ramp_speed];
        prod  = sdr_pkg::PROD_W'(mag) * sdr_pkg::PROD_W'(recip);
        quot  = prod[sdr_pkg::RECIP_SH +: sdr_pkg::QUOT_W];
        if (quot == '0) begin
            step_calc = sdr_pkg::STEP_W'(1);
        end else if (diff[sdr_pkg::DUTY_W]) begin
            step_calc = ~{1'b0, quot} + 1'b1;
        end else begin
            step_calc = {1'b0, quot};
        end

        sum      = {4'b0, cur_reg} + {{2{step_reg[sdr_pkg::STEP_W-1]}}, step_reg};
        tgt_ext  = {4'b0, tgt_reg};
        step_pos = !step_reg[sdr_pkg::STEP_W-1] && (step_reg != '0);

        cur_next  = cur_reg;
        tgt_next  = tgt_reg;
        step_next = step_reg;
        ramp_next = ramp_reg;
        pwr_next  = pwr_reg;
        res_next.status       = sdr_pkg::ST_OK;
        res_next.duty_written = 1'b0;

        case (op)
            sdr_pkg::OP_TICK: begin
                if (ramp_reg && (cur_reg != tgt_reg)) begin
                    if (step_pos ? ($signed(sum) > $signed(tgt_ext))
                                 : ($signed(sum) < $signed(tgt_ext))) begin
                        cur_next = tgt_reg;
                    end else begin
                        cur_next = sum[sdr_pkg::DUTY_W-1:0];
                    end
                    res_next.duty_written = 1'b1;
                end
            end
            sdr_pkg::OP_MOVE: begin
                if ((in_item.target_position < min_pos_reg) ||
                    (in_item.target_position > max_pos_reg)) begin
                    res_next.status = sdr_pkg::ST_RANGE;
                end else if (want == cur_reg) begin
                    res_next.status = sdr_pkg::ST_SAME;
                end else if (in_item.ramp_speed == '0) begin
                    res_next.status = sdr_pkg::ST_ZERO_SPEED;
                end else begin
                    pwr_next  = 1'b1;
                    tgt_next  = want;
                    step_next = step_calc;
                    ramp_next = 1'b1;
                end
            end
            sdr_pkg::OP_STANDBY: begin
                pwr_next = 1'b1;
                tgt_next = stby_duty;
                cur_next = stby_duty;
                res_next.duty_written = 1'b1;
            end
            sdr_pkg::OP_STOP: begin
                cur_next  = tgt_reg;
                ramp_next = 1'b0;
            end
            sdr_pkg::OP_POWER_OFF: begin
                pwr_next = 1'b0;
            end
            default: ;
        endcase

        res_next.duty_ns = cur_next;
        res_next.powered = pwr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= sdr_pkg::DUTY_MIN;
            tgt_reg       <= sdr_pkg::DUTY_MIN;
            step_reg      <= '0;
            ramp_reg      <= 1'b0;
            pwr_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                cur_reg  <= cur_next;
                tgt_reg  <= tgt_next;
                step_reg <= step_next;
                ramp_reg <= ramp_next;
                pwr_reg  <= pwr_next;
            end
            if (in_take) begin
                res_valid_reg <= 1'b1;
            end else if (res_take) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            res_reg <= res_next;
        end
    end

endmodule

[hdl/sdr_posn.sv]
// ============================================================================
// Servo duty ramp position stage
// Derive the position from the pulse width and hold the output word.
// ============================================================================
module sdr_posn (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              res_valid,
    input  sdr_pkg::result_t                  res,
    output logic                              res_take,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sdr_pkg::STATUS_W-1:0]      m_status,
    output logic [sdr_pkg::DUTY_W-1:0]        m_duty_ns,
    output logic                              m_duty_written,
    output logic [sdr_pkg::POS_W-1:0]         m_position_now,
    output logic                              m_powered
);

    logic                                 m_valid_reg;
    sdr_pkg::result_t                     out_reg;
    logic [sdr_pkg::POS_W-1:0]            pos_reg, pos_next;
    logic [sdr_pkg::DUTY_W-1:0]           offset;
    logic [sdr_pkg::POS_PROD_W-1:0]       pos_prod;

    assign res_take = !m_valid_reg || m_ready;

    always_comb begin
        offset   = res.duty_ns - sdr_pkg::DUTY_MIN;
        pos_prod = sdr_pkg::POS_PROD_W'(offset[sdr_pkg::DUTY_W-1:sdr_pkg::POS_SHIFT])
                   * sdr_pkg::POS_PROD_W'(sdr_pkg::POS_RECIP);
        if (res.duty_ns < sdr_pkg::DUTY_MIN) begin
            pos_next = '0;
        end else begin
            pos_next = pos_prod[sdr_pkg::POS_RECIP_SH +: sdr_pkg::POS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take && res_valid) begin
            out_reg <= res;
            pos_reg <= pos_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_reg.status;
    assign m_duty_ns      = out_reg.duty_ns;
    assign m_duty_written = out_reg.duty_written;
    assign m_position_now = pos_reg;
    assign m_powered      = out_reg.powered;

endmodule

[hdl/servo_duty_ramp_unit.sv]
// Path: an accepted input word passes the input, result and output registers.
// Throughput: one word per cycle while m_ready does not stall the output; the
// ramp state updates in a single pass between the input register and the result
// register, then the position divide-by-constant fills the output register.
// Reset: synchronous, active low; duty 600000 ns, no ramp, power off,
// positions 0 / 100 / 50.
// ============================================================================
// Servo duty ramp unit
// Servo set-point ramp: moves, standby, stop, power off and ramp ticks.
// ============================================================================
module servo_duty_ramp_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [sdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdr_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sdr_pkg::OP_W-1:0]          s_operation,
    input  logic [sdr_pkg::POS_W-1:0]         s_target_position,
    input  logic [sdr_pkg::SPEED_W-1:0]       s_ramp_speed,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sdr_pkg::STATUS_W-1:0]      m_status,
    output logic [sdr_pkg::DUTY_W-1:0]        m_duty_ns,
    output logic                              m_duty_written,
    output logic [sdr_pkg::POS_W-1:0]         m_position_now,
    output logic                              m_powered
);

    logic              in_valid_reg;
    sdr_pkg::item_t    in_item_reg;
    logic              core_take;
    logic              res_valid;
    sdr_pkg::result_t  res;
    logic              res_take;

    assign s_ready = !in_valid_reg || core_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (core_take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.operation       <= s_operation;
            in_item_reg.target_position <= s_target_position;
            in_item_reg.ramp_speed      <= s_ramp_speed;
        end
    end

    sdr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .in_take   (core_take),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    sdr_posn u_posn (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res_valid      (res_valid),
        .res            (res),
        .res_take       (res_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_duty_ns      (m_duty_ns),
        .m_duty_written (m_duty_written),
        .m_position_now (m_position_now),
        .m_powered      (m_powered)
    );

endmodule

[hdl/sdr_checker.sv]
// ============================================================================
// Servo duty ramp checker
// Port-level assertions on the servo duty ramp unit, bound to the top level.
// ============================================================================
`include "servo_duty_ramp_unit_assert.svh"

module sdr_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [sdr_pkg::STATUS_W-1:0]      m_status,
    input  logic [sdr_pkg::DUTY_W-1:0]        m_duty_ns,
    input  logic                              m_duty_written
);

    // drop any output word while in reset
    `SDR_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "output word valid after reset")

    // hold a stalled word
    `SDR_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_duty_ns) && $stable(m_status) && $stable(m_duty_written), "stalled output word changed")

    `SDR_ASSERT(a_reject_no_write, aclk, aresetn, m_valid && (m_status != sdr_pkg::ST_OK) |-> !m_duty_written, "rejected move wrote the duty")

    `SDR_ASSERT(a_duty_range, aclk, aresetn, m_valid |-> (m_duty_ns >= sdr_pkg::DUTY_MIN) && (m_duty_ns <= sdr_pkg::DUTY_MAX), "duty outside the position span")

endmodule

bind servo_duty_ramp_unit sdr_checker u_sdr_checker (.*);
